FILE: rtl/rsel_pkg.sv
// ============================================================================
// rsel_pkg
// Shared command and status types for the row subpixel edge locator.
// ============================================================================
`default_nettype none

package rsel_pkg;

  // Which extreme of the row is being refined.
  localparam logic SEL_PEAK   = 1'b0;
  localparam logic SEL_TROUGH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // sample request accepted this cycle
    logic load;   // set up the fit for the selected extreme
    logic fix;    // apply the offset and store the position
    logic emit;   // load the result register and clear the row state
    logic sel;    // selected extreme
  } rsel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic apply;     // the selected extreme gets an offset
    logic div_done;  // quotient is ready
    logic out_free;  // result register can take a new result
  } rsel_status_t;

endpackage

`default_nettype wire

FILE: rtl/row_subpixel_edge_locator.sv
// Row subpixel edge locator. Gradient samples of a row enter one per cycle
// while the row runs. The request that carries tlast ends the row; the input
// then stalls while the peak and the trough are refined one after the other
// on a shared restoring divider that yields one quotient bit per cycle. Each
// refinement sets up the fit, runs the divider only when an offset is
// computed, and stores the position; then the result register is loaded.
// A finished result sits in an output register and the next row is taken
// while it waits; a row end holds the input longer only if that register
// is still full.
// ============================================================================
// row_subpixel_edge_locator
// Locates rising and falling edge positions of a row to a fraction of a pixel.
// ============================================================================
`default_nettype none

module row_subpixel_edge_locator #(
  parameter int MAX_ROW     = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // gradient_sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tlast,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // rising_pos_q8, falling_pos_q8, edge_width_q8
  output logic [((2*($clog2(MAX_ROW)+FRAC_BITS)+$clog2(MAX_ROW)+FRAC_BITS+1+7)/8)*8-1:0]
                    out_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready
);
  import rsel_pkg::*;

  rsel_cmd_t    cmd;
  rsel_status_t status;

  rsel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rsel_datapath #(
    .MAX_ROW     (MAX_ROW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/rsel_div.sv
// ============================================================================
// rsel_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module rsel_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      // The remainder always stays below the divisor, so it fits DEN_W bits.
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

FILE: rtl/rsel_datapath.sv
// ============================================================================
// rsel_datapath
// Extreme tracking, parabolic fit setup, offset and clamp, result register.
// ============================================================================
`default_nettype none

module rsel_datapath #(
  parameter int MAX_ROW     = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rsel_pkg::rsel_cmd_t cmd,
  output rsel_pkg::rsel_status_t   status,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [((2*($clog2(MAX_ROW)+FRAC_BITS)+$clog2(MAX_ROW)+FRAC_BITS+1+7)/8)*8-1:0]
                                   out_data
);
  import rsel_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CIW   = $clog2(MAX_ROW);
  localparam int CCW   = $clog2(MAX_ROW + 1);
  localparam int POSW  = CIW + FRAC_BITS;
  localparam int WW    = POSW + 1;
  localparam int OW    = 2 * POSW + WW;
  localparam int ODW   = ((OW + 7) / 8) * 8;
  localparam int DSW   = SB + 4;
  localparam int NW    = SB + FRAC_BITS + 2;
  localparam int SW    = ((NW > POSW) ? NW : POSW) + 2;

  typedef struct packed {
    logic signed [SB-1:0] value;
    logic [CIW-1:0]       column;
    logic signed [SB-1:0] prior;
    logic signed [SB-1:0] after;
    logic                 pending;
  } ext_t;

  function automatic ext_t take_ext(ext_t e, logic signed [SB-1:0] s,
                                    logic [CIW-1:0] col, logic is_max,
                                    logic signed [SB-1:0] prev);
    ext_t r;
    logic better;
    r      = e;
    better = is_max ? (s > e.value) : (s < e.value);
    if (col == '0 || better) begin
      r.value   = s;
      r.column  = col;
      r.prior   = (col == '0) ? '0 : prev;
      r.after   = '0;
      r.pending = 1'b1;
    end else if (e.pending) begin
      r.after   = s;
      r.pending = 1'b0;
    end
    return r;
  endfunction

  ext_t                 peak_r;
  ext_t                 trough_r;
  ext_t                 cur;
  logic signed [SB-1:0] prev_r;
  logic [CCW-1:0]       count_r;
  logic                 in_range;
  logic signed [SB-1:0] s;

  logic signed [DSW-1:0] a_x, b_x, c_x, d, nu;
  logic [DSW-1:0]        d_abs, nu_abs;
  logic [NW-1:0]         num;
  logic [DSW-1:0]        den;
  logic                  apply_now;
  logic                  apply_r;
  logic                  neg_r;
  logic                  div_start;
  logic                  div_done;
  logic [NW-1:0]         quot;

  logic signed [SW-1:0]  base;
  logic signed [SW-1:0]  offset;
  logic signed [SW-1:0]  pos;
  logic [POSW-1:0]       pos_clamped;
  logic [POSW-1:0]       rise_r;
  logic [POSW-1:0]       fall_r;
  logic [WW-1:0]         width;
  logic [ODW-1:0]        out_data_r;
  logic                  out_valid_r;

  localparam logic signed [SW-1:0] MAX_POS = SW'(MAX_ROW - 1) <<< FRAC_BITS;

  assign s        = sample;
  assign in_range = count_r < CCW'(MAX_ROW);

  // Row tracking; samples past the row limit are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r   <= '0;
      trough_r <= '0;
      prev_r   <= '0;
      count_r  <= '0;
    end else if (cmd.emit) begin
      peak_r   <= '0;
      trough_r <= '0;
      prev_r   <= '0;
      count_r  <= '0;
    end else if (cmd.take && in_range) begin
      peak_r   <= take_ext(peak_r, s, count_r[CIW-1:0], 1'b1, prev_r);
      trough_r <= take_ext(trough_r, s, count_r[CIW-1:0], 1'b0, prev_r);
      prev_r   <= s;
      count_r  <= count_r + 1'b1;
    end
  end

  // Fit setup: d = 2a - 4b + 2c, numerator a - c.
  assign cur    = (cmd.sel == SEL_TROUGH) ? trough_r : peak_r;
  assign a_x    = DSW'(cur.prior);
  assign b_x    = DSW'(cur.value);
  assign c_x    = DSW'(cur.after);
  assign d      = (a_x <<< 1) - (b_x <<< 2) + (c_x <<< 1);
  assign nu     = a_x - c_x;
  assign d_abs  = d[DSW-1] ? DSW'(-d) : DSW'(d);
  assign nu_abs = nu[DSW-1] ? DSW'(-nu) : DSW'(nu);
  // Rounded quotient: (2n + m) / (2m) with n = |a - c| scaled by the fraction.
  assign num    = (NW'(nu_abs[SB-1:0]) << (FRAC_BITS + 1)) + NW'(d_abs);
  assign den    = d_abs << 1;

  assign apply_now = (cur.column != '0) && !cur.pending && (d != '0);
  assign div_start = cmd.load && apply_now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      apply_r <= apply_now;
      neg_r   <= nu[DSW-1] != d[DSW-1];
    end
  end

  rsel_div #(
    .NUM_W (NW),
    .DEN_W (DSW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // Offset and clamp to the row.
  assign base   = SW'(cur.column) <<< FRAC_BITS;
  assign offset = apply_r ? SW'(quot) : '0;
  assign pos    = neg_r ? base - offset : base + offset;

  always_comb begin
    priority if (pos < 0) begin
      pos_clamped = '0;
    end else if (pos > MAX_POS) begin
      pos_clamped = MAX_POS[POSW-1:0];
    end else begin
      pos_clamped = pos[POSW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      if (cmd.sel == SEL_TROUGH) begin
        fall_r <= pos_clamped;
      end else begin
        rise_r <= pos_clamped;
      end
    end
  end

  assign width = WW'(fall_r) - WW'(rise_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= ODW'({width, fall_r, rise_r});
    end
  end

  assign status.apply    = apply_now;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/rsel_ctrl.sv
// ============================================================================
// rsel_ctrl
// Sequencer: sample intake, then fit of the peak and the trough, then emit.
// ============================================================================
`default_nettype none

module rsel_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_last,
  output logic                        in_ready,
  input  wire rsel_pkg::rsel_status_t status,
  output rsel_pkg::rsel_cmd_t         cmd
);
  import rsel_pkg::*;

  typedef enum logic [2:0] {
    S_RUN,
    S_LOAD,
    S_DIV,
    S_FIX,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      sel_r   <= SEL_PEAK;
    end else begin
      unique case (state_r)
        S_RUN: begin
          if (in_valid && in_last) begin
            state_r <= S_LOAD;
            sel_r   <= SEL_PEAK;
          end
        end
        S_LOAD: begin
          state_r <= status.apply ? S_DIV : S_FIX;
        end
        S_DIV: begin
          if (status.div_done) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          if (sel_r == SEL_PEAK) begin
            sel_r   <= SEL_TROUGH;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (status.out_free) begin
            state_r <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign in_ready = state_r == S_RUN;

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel_r;
    cmd.take = (state_r == S_RUN) && in_valid;
    cmd.load = state_r == S_LOAD;
    cmd.fix  = state_r == S_FIX;
    cmd.emit = (state_r == S_EMIT) && status.out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/rsel_assert.sv
// ============================================================================
// rsel_assert
// Port-level checks of the row subpixel edge locator, bound to the top level.
// ============================================================================
`default_nettype none

module rsel_assert #(
  parameter int MAX_ROW     = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tlast,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic [((2*($clog2(MAX_ROW)+FRAC_BITS)+$clog2(MAX_ROW)+FRAC_BITS+1+7)/8)*8-1:0]
                   out_tdata,
  input wire logic out_tvalid,
  input wire logic out_tready
);

  localparam int POSW = $clog2(MAX_ROW) + FRAC_BITS;
  localparam int WW   = POSW + 1;
  localparam logic [POSW-1:0] MAX_POS = POSW'(MAX_ROW - 1) << FRAC_BITS;

  logic [POSW-1:0] rise;
  logic [POSW-1:0] fall;
  logic [WW-1:0]   width;
  logic [WW-1:0]   width_exp;

  assign rise      = out_tdata[POSW-1:0];
  assign fall      = out_tdata[2*POSW-1:POSW];
  assign width     = out_tdata[2*POSW+WW-1:2*POSW];
  assign width_exp = WW'(fall) - WW'(rise);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> width == width_exp)
    else $error("edge width is not falling minus rising position");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> rise <= MAX_POS && fall <= MAX_POS)
    else $error("edge position outside the row");

  // The row end starts the fit, so the next sample has to wait.
  a_row_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after a row end");

endmodule

bind row_subpixel_edge_locator rsel_assert #(
  .MAX_ROW     (MAX_ROW),
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_rsel_assert (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tlast   (in_tlast),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

FILE: sim/row_subpixel_edge_locator_test.sv
// ----------------------------------------------------------------------------
// Row subpixel edge locator testbench
// Streams rows of gradient samples into the block, predicts the rising and
// falling edge positions of each row with its own parabolic-fit model, and
// checks every result field as it leaves the block, under random idling on
// both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module row_subpixel_edge_locator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_LIMIT   = 1024;
  localparam int FRAC_BITS   = 8;
  localparam int ITEMS       = 1850;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic signed [15:0] value;
    logic [9:0]         column;
    logic signed [15:0] prior;
    logic signed [15:0] after;
    bit                 after_pending;
  } extremum_t;

  typedef struct {
    logic [17:0] rising;
    logic [17:0] falling;
    logic [18:0] width;
  } edge_result_t;

  class edge_scoreboard;
    extremum_t          peak;
    extremum_t          trough;
    logic signed [15:0] last_sample;
    int unsigned        row_columns;
    edge_result_t       edge_results_q[$];
    int                 errors;
    int                 checked;

    function new();
      clear_row();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_row();
      peak        = '{default: '0};
      trough      = '{default: '0};
      last_sample = '0;
      row_columns = 0;
    endfunction

    // Only a strictly better sample moves an extreme; column zero always seeds it.
    function extremum_t track_extreme(extremum_t e, logic signed [15:0] s,
                                      logic [9:0] col, bit want_max);
      bit better;
      better = want_max ? (s > e.value) : (s < e.value);
      if (col == 0 || better) begin
        e.value         = s;
        e.column        = col;
        e.prior         = (col == 0) ? 16'sd0 : last_sample;
        e.after         = '0;
        e.after_pending = 1'b1;
      end else if (e.after_pending) begin
        e.after         = s;
        e.after_pending = 1'b0;
      end
      return e;
    endfunction

    function logic [17:0] refine_position(extremum_t e);
      longint base, maxpos, a, b, c, d, nu, n, m, q;
      base   = longint'(e.column) << FRAC_BITS;
      maxpos = longint'(ROW_LIMIT - 1) << FRAC_BITS;
      if (e.column != 0 && !e.after_pending) begin
        a  = e.prior;
        b  = e.value;
        c  = e.after;
        d  = 2 * a - 4 * b + 2 * c;
        nu = a - c;
        if (d != 0) begin
          n = (nu < 0 ? -nu : nu) << FRAC_BITS;
          m = d < 0 ? -d : d;
          // Round to nearest, halves away from zero.
          q = (2 * n + m) / (2 * m);
          base = ((nu < 0) != (d < 0)) ? base - q : base + q;
        end
      end
      if (base < 0) base = 0;
      if (base > maxpos) base = maxpos;
      return base[17:0];
    endfunction

    function void note_sample(logic signed [15:0] s, logic row_end);
      edge_result_t res;
      longint       rise, fall, w;
      if (row_columns < ROW_LIMIT) begin
        peak        = track_extreme(peak, s, row_columns[9:0], 1'b1);
        trough      = track_extreme(trough, s, row_columns[9:0], 1'b0);
        last_sample = s;
        row_columns++;
      end
      if (row_end) begin
        rise        = refine_position(peak);
        fall        = refine_position(trough);
        w           = fall - rise;
        res.rising  = rise[17:0];
        res.falling = fall[17:0];
        res.width   = w[18:0];
        edge_results_q.insert(edge_results_q.size(), res);
        clear_row();
      end
    endfunction

    function void check_result(logic [55:0] data);
      edge_result_t want;
      checked++;
      if (edge_results_q.size() == 0) begin
        $error("edge result %h arrived with no row pending", data);
        errors++;
        return;
      end
      want = edge_results_q.pop_front();
      if (data[17:0] !== want.rising) begin
        $error("rising_pos_q8: expected %0d, got %0d", want.rising, data[17:0]);
        errors++;
      end
      if (data[35:18] !== want.falling) begin
        $error("falling_pos_q8: expected %0d, got %0d", want.falling, data[35:18]);
        errors++;
      end
      if (data[54:36] !== want.width) begin
        $error("edge_width_q8: expected %0d, got %0d", $signed(want.width),
               $signed(data[54:36]));
        errors++;
      end
    endfunction

    function void drain_check();
      if (edge_results_q.size() != 0) begin
        $error("%0d edge results never arrived", edge_results_q.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  edge_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int          items_sent    = 0;
  bit          calm          = 1'b0;
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  bit          hold_done     = 1'b0;
  int          hold_left     = 0;
  int          rx_stall_left = 0;

  row_subpixel_edge_locator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side: random stall bursts, plus one long hold-off that backs up the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (rx_stall_left != 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else if (!calm && rx_idle_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      rx_stall_left = $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
    if (rst_n && !hold_done && sb.checked >= 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (cycle_count % 256 == 0) rx_idle_on = $urandom_range(0, 2) != 0;
  end

  task automatic send_sample(input logic signed [15:0] s, input logic row_end);
    in_tdata  <= s;
    in_tlast  <= row_end;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s, row_end);
    items_sent++;
    if (!calm && tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Row shapes: 0 full random, 1 tiny values full of ties, 2 noise with a
  // peak and a dip, 3 only the field extremes and values around zero.
  task automatic send_row(input int len, input int shape);
    logic signed [15:0] row_q[ROW_LIMIT + 16];
    int                 i, at, amp, taken;
    for (i = 0; i < len; i++) begin
      case (shape)
        0: row_q[i] = 16'($urandom);
        1: row_q[i] = 16'(int'($urandom_range(0, 4)) - 2);
        2: row_q[i] = 16'(int'($urandom_range(0, 200)) - 100);
        default: begin
          case ($urandom_range(0, 4))
            0: row_q[i] = 16'sh7fff;
            1: row_q[i] = 16'sh8000;
            2: row_q[i] = 16'sd0;
            3: row_q[i] = -16'sd1;
            default: row_q[i] = 16'sd1;
          endcase
        end
      endcase
    end
    if (shape == 2) begin
      taken = (len < ROW_LIMIT) ? len : ROW_LIMIT;
      // Often put the peak on the last column the block takes.
      at  = ($urandom_range(0, 3) == 0) ? taken - 1 : $urandom_range(0, len - 1);
      amp = $urandom_range(200, 32767);
      row_q[at] = 16'(amp);
      if (at > 0) row_q[at-1] = 16'(amp - int'($urandom_range(1, amp)));
      if (at < len - 1) row_q[at+1] = 16'(amp - int'($urandom_range(1, amp)));
      at  = $urandom_range(0, len - 1);
      amp = $urandom_range(200, 32768);
      row_q[at] = 16'(-amp);
      if (at > 0) row_q[at-1] = 16'(-amp + int'($urandom_range(1, amp)));
      if (at < len - 1) row_q[at+1] = 16'(-amp + int'($urandom_range(1, amp)));
    end
    for (i = 0; i < len; i++) send_sample(row_q[i], i == len - 1);
  endtask

  initial begin
    int  len;
    bit  long_done;
    int  wait_cycles;
    long_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample rows at both field extremes.
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    // Interior maximum and minimum at the field extremes.
    send_sample(16'sd0, 1'b0); send_sample(16'sh7fff, 1'b0); send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0); send_sample(16'sd5, 1'b1);
    // Ties: the first maximum and the first minimum must win.
    send_sample(16'sd3, 1'b0); send_sample(16'sd7, 1'b0); send_sample(16'sd7, 1'b0);
    send_sample(-16'sd2, 1'b0); send_sample(-16'sd2, 1'b0); send_sample(16'sd1, 1'b1);
    // Maximum at column zero, minimum on the last sample.
    send_sample(16'sd100, 1'b0); send_sample(16'sd50, 1'b0); send_sample(16'sd20, 1'b0);
    send_sample(-16'sd10, 1'b1);
    // Flat row: both extremes stay at column zero.
    send_sample(16'sd9, 1'b0); send_sample(16'sd9, 1'b0); send_sample(16'sd9, 1'b1);
    // Two-sample row.
    send_sample(-16'sd5, 1'b0); send_sample(16'sd6, 1'b1);

    while (items_sent < ITEMS) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      if (!long_done && items_sent >= 500) begin
        // One row longer than the block keeps; the tail is ignored.
        send_row(ROW_LIMIT + $urandom_range(1, 12), 2);
        long_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
        send_row(len, $urandom_range(0, 3));
      end
      calm = items_sent >= ITEMS - 150;
    end
    in_tvalid <= 1'b0;

    while (sb.edge_results_q.size() != 0) @(posedge clk);
    wait_cycles = 100;
    repeat (wait_cycles) @(posedge clk);
    sb.drain_check();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rsel_pkg.sv
rtl/rsel_div.sv
rtl/rsel_datapath.sv
rtl/rsel_ctrl.sv
rtl/row_subpixel_edge_locator.sv
rtl/rsel_assert.sv
sim/row_subpixel_edge_locator_test.sv
